@@ rtl/hfts_pkg.sv @@
package hfts_pkg;

    localparam int NODE_W      = 32;
    localparam int LEVEL_W     = 8;
    localparam int COORD_IN_W  = 10;
    localparam int FRAC_IN_W   = 16;
    localparam int UNIT_W      = 16;
    localparam int GRID_SIDE_W = 9;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int HEIGHT_W    = 26;
    localparam int IN_TDATA_W  = 88;
    localparam int OUT_TDATA_W = 32;
    localparam int CORNER_W    = 27;
    localparam int DIFF_W      = CORNER_W + 1;

    localparam logic [LEVEL_W-1:0] SLOPE_CENTER = 8'h02;

    localparam logic [CFG_INDEX_W-1:0] REG_GRID_SIDE   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT_UNIT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CLIFF_UNIT  = 2'd2;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [1:0] {
        MODE_HEIGHT = 2'd0,
        MODE_CLIFF  = 2'd1,
        MODE_FULL   = 2'd2
    } mode_t;

    // Height of one node in 1/256 units. Any code other than height-only or
    // height-plus-cliff takes the full formula.
    function automatic logic signed [CORNER_W-1:0] corner_value(
        input logic [NODE_W-1:0] word,
        input mode_t             mode,
        input logic [UNIT_W-1:0] height_unit,
        input logic [UNIT_W-1:0] cliff_unit
    );
        logic [LEVEL_W+UNIT_W-1:0]  h_term;
        logic signed [LEVEL_W:0]    level;
        logic signed [CORNER_W-1:0] l_term;
        logic [UNIT_W-1:0]          half;
        h_term = (LEVEL_W+UNIT_W)'(word[LEVEL_W-1:0]) * (LEVEL_W+UNIT_W)'(height_unit);
        half   = '0;
        case (mode)
            MODE_HEIGHT:
            begin
                level = '0;
            end
            MODE_CLIFF:
            begin
                level = $signed({1'b0, word[2*LEVEL_W-1:LEVEL_W]});
            end
            default:
            begin
                level = $signed({1'b0, word[2*LEVEL_W-1:LEVEL_W]})
                      - $signed({1'b0, word[3*LEVEL_W-1:2*LEVEL_W]});
                if (word[4*LEVEL_W-1:3*LEVEL_W] == SLOPE_CENTER)
                begin
                    half = cliff_unit >> 1;
                end
            end
        endcase
        l_term = CORNER_W'(level) * $signed(CORNER_W'(cliff_unit));
        return $signed(CORNER_W'(h_term)) + l_term + $signed(CORNER_W'(half));
    endfunction

endpackage

@@ rtl/hfts_ram.sv @@
module hfts_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 65536,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/heightfield_triangle_sample_unit.sv @@
// Terrain height sampler over a square grid of nodes.
// Input stream (s_*): one transaction per item. s_tuser is the command: a
// write stores one node word, a query samples the terrain height at a node
// position plus a fraction within the cell. Positions are clamped to the grid.
// Output stream (m_*): exactly one transaction per input item, in order.
// m_tuser flags a write acknowledge; m_tdata carries the height (0 for writes).
// Configuration: cfg_wr_en/cfg_index/cfg_data write grid side, height unit and
// cliff unit; write them only while no item is in flight.
// Items pass registers s1 to s4 and the result queue. One item is accepted
// every cycle while s_tready is high: a query reads its three corner nodes at
// once from three node store copies, which every write updates at the same address.
// A write is visible to a query accepted in the very next cycle.
// Up to 8 items may be in flight between the two sides; s_tready drops once 8
// items are in flight, which happens only while the receiver stalls, and rises
// again right after the next output transaction.
// Reset empties the pipeline and the result queue and restores the register
// defaults; node contents are undefined until written.
module heightfield_triangle_sample_unit #(
    parameter int MAX_SIDE  = 256,
    parameter int FRAC_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // node_x, node_z, frac_x, frac_z, mode, new_height, new_cliff, new_water,
    // new_slope, zero padding
    input  logic [hfts_pkg::IN_TDATA_W-1:0]     s_tdata,
    // command
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // height, zero padding
    output logic [hfts_pkg::OUT_TDATA_W-1:0]    m_tdata,
    // was_write
    output logic                                m_tuser,
    input  logic                                cfg_wr_en,
    input  logic [hfts_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [hfts_pkg::CFG_DATA_W-1:0]     cfg_data
);

    import hfts_pkg::*;

    localparam int SIDE_W     = $clog2(MAX_SIDE + 1);
    localparam int CW         = (MAX_SIDE > 2) ? $clog2(MAX_SIDE) : 1;
    localparam int DEPTH      = MAX_SIDE * MAX_SIDE;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CMP_W      = (SIDE_W > COORD_IN_W) ? SIDE_W : COORD_IN_W;
    localparam int RESET_SIDE = (MAX_SIDE < 256) ? MAX_SIDE : 256;
    localparam int WT_W       = FRAC_BITS + 1;
    localparam int PROD_W     = DIFF_W + WT_W + 1;
    localparam int ACC_W      = PROD_W + 2;
    localparam int Q_DEPTH    = 8;
    localparam int Q_PTR_W    = $clog2(Q_DEPTH);
    localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

    localparam logic [WT_W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    // ---------------- configuration ----------------
    logic [SIDE_W-1:0]  side_reg,        side_next;
    logic [CW-1:0]      side_m1_reg;
    logic [UNIT_W-1:0]  height_unit_reg;
    logic [UNIT_W-1:0]  cliff_unit_reg;
    logic [CMP_W-1:0]   cfg_side_wide;

    assign cfg_side_wide = CMP_W'(cfg_data[GRID_SIDE_W-1:0]);

    always_comb
    begin
        if (cfg_side_wide < CMP_W'(2))
        begin
            side_next = SIDE_W'(2);
        end
        else if (cfg_side_wide > CMP_W'(MAX_SIDE))
        begin
            side_next = SIDE_W'(MAX_SIDE);
        end
        else
        begin
            side_next = SIDE_W'(cfg_side_wide);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg        <= SIDE_W'(RESET_SIDE);
            side_m1_reg     <= CW'(RESET_SIDE - 1);
            height_unit_reg <= UNIT_W'(256);
            cliff_unit_reg  <= UNIT_W'(256);
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_GRID_SIDE:
                begin
                    side_reg    <= side_next;
                    side_m1_reg <= CW'(side_next - SIDE_W'(1));
                end
                REG_HEIGHT_UNIT:
                begin
                    height_unit_reg <= cfg_data;
                end
                REG_CLIFF_UNIT:
                begin
                    cliff_unit_reg <= cfg_data;
                end
                default:
                begin
                end
            endcase
        end
    end

    // ---------------- input decode and store addressing ----------------
    logic signed [COORD_IN_W-1:0] node_x, node_z;
    logic [FRAC_IN_W-1:0]         frac_x, frac_z;
    logic [1:0]                   mode_in;
    logic [NODE_W-1:0]            node_word;
    logic                         in_accept, in_write, in_query;

    assign node_x    = $signed(s_tdata[9:0]);
    assign node_z    = $signed(s_tdata[19:10]);
    assign frac_x    = s_tdata[35:20];
    assign frac_z    = s_tdata[51:36];
    assign mode_in   = s_tdata[53:52];
    assign node_word = s_tdata[85:54];
    assign in_accept = s_tvalid && s_tready;
    assign in_write  = in_accept && (s_tuser == CMD_WRITE);
    assign in_query  = in_accept && (s_tuser == CMD_QUERY);

    function automatic logic [CW-1:0] clamp_pos(
        input logic signed [COORD_IN_W-1:0] p,
        input logic [CW-1:0]                last
    );
        logic [CW-1:0] r;
        if (p < 0)
        begin
            r = '0;
        end
        else if (CMP_W'(p[COORD_IN_W-2:0]) > CMP_W'(last))
        begin
            r = last;
        end
        else
        begin
            r = CW'(p[COORD_IN_W-2:0]);
        end
        return r;
    endfunction

    logic [CW-1:0]        pos_x, pos_z;
    logic                 x_step, z_step;
    logic [ADDR_W-1:0]    z_ext, side_ext, addr_00, addr_01, addr_10, addr_11, addr_base;
    logic [FRAC_BITS-1:0] fx_in, fz_in;
    logic                 upper_in;

    assign pos_x    = clamp_pos(node_x, side_m1_reg);
    assign pos_z    = clamp_pos(node_z, side_m1_reg);
    // The +1 neighbor stays on the last node at the far edge.
    assign x_step   = (pos_x != side_m1_reg);
    assign z_step   = (pos_z != side_m1_reg);
    assign z_ext    = ADDR_W'(pos_z);
    assign side_ext = ADDR_W'(side_reg);
    assign addr_00  = z_ext * side_ext + ADDR_W'(pos_x);
    assign addr_01  = addr_00 + (z_step ? side_ext : '0);
    assign addr_10  = addr_00 + ADDR_W'(x_step);
    assign addr_11  = addr_01 + ADDR_W'(x_step);

    assign fx_in     = FRAC_BITS'(frac_x);
    assign fz_in     = FRAC_BITS'(frac_z);
    assign upper_in  = ({1'b0, fx_in} + {1'b0, fz_in}) > ONE;
    assign addr_base = upper_in ? addr_11 : addr_00;

    // Three copies of the node store, one per corner read port.
    logic [NODE_W-1:0] word_c1, word_c2, word_base;

    hfts_ram #(.WIDTH(NODE_W), .DEPTH(DEPTH)) u_ram_c1 (
        .clk     (clk),
        .wr_en   (in_write),
        .wr_addr (addr_00),
        .wr_data (node_word),
        .rd_en   (in_query),
        .rd_addr (addr_01),
        .rd_data (word_c1)
    );

    hfts_ram #(.WIDTH(NODE_W), .DEPTH(DEPTH)) u_ram_c2 (
        .clk     (clk),
        .wr_en   (in_write),
        .wr_addr (addr_00),
        .wr_data (node_word),
        .rd_en   (in_query),
        .rd_addr (addr_10),
        .rd_data (word_c2)
    );

    hfts_ram #(.WIDTH(NODE_W), .DEPTH(DEPTH)) u_ram_base (
        .clk     (clk),
        .wr_en   (in_write),
        .wr_addr (addr_00),
        .wr_data (node_word),
        .rd_en   (in_query),
        .rd_addr (addr_base),
        .rd_data (word_base)
    );

    // ---------------- pipeline ----------------
    logic                 s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic                 s1_write_reg, s2_write_reg, s3_write_reg, s4_write_reg;
    logic                 s1_upper_reg, s2_upper_reg;
    logic [FRAC_BITS-1:0] s1_fx_reg, s1_fz_reg, s2_fx_reg, s2_fz_reg;
    logic [1:0]           s1_mode_reg;

    logic signed [CORNER_W-1:0] s2_base_reg, s2_c1_reg, s2_c2_reg, s3_base_reg, s4_base_reg;
    logic signed [DIFF_W-1:0]   s3_da_reg, s3_db_reg, da_next, db_next;
    logic [WT_W-1:0]            s3_wa_reg, s3_wb_reg, wa_next, wb_next;
    logic signed [PROD_W-1:0]   s4_pa_reg, s4_pb_reg, pa_next, pb_next;
    logic signed [ACC_W-1:0]    acc_sum, acc_shift;
    logic [HEIGHT_W-1:0]        height_next;

    // Lower triangle: base c0, c2 weighted by fx, c1 by fz.
    // Upper triangle: base c3, c2 weighted by 1-fz, c1 by 1-fx.
    assign da_next = DIFF_W'(s2_c2_reg) - DIFF_W'(s2_base_reg);
    assign db_next = DIFF_W'(s2_c1_reg) - DIFF_W'(s2_base_reg);
    assign wa_next = s2_upper_reg ? (ONE - WT_W'(s2_fz_reg)) : WT_W'(s2_fx_reg);
    assign wb_next = s2_upper_reg ? (ONE - WT_W'(s2_fx_reg)) : WT_W'(s2_fz_reg);

    assign pa_next = PROD_W'(s3_da_reg) * $signed(PROD_W'(s3_wa_reg));
    assign pb_next = PROD_W'(s3_db_reg) * $signed(PROD_W'(s3_wb_reg));

    // The arithmetic shift rounds toward minus infinity.
    assign acc_sum     = (ACC_W'(s4_base_reg) <<< FRAC_BITS) + ACC_W'(s4_pa_reg)
                       + ACC_W'(s4_pb_reg);
    assign acc_shift   = acc_sum >>> FRAC_BITS;
    assign height_next = s4_write_reg ? '0 : acc_shift[HEIGHT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_write_reg <= (s_tuser == CMD_WRITE);
        s1_upper_reg <= upper_in;
        s1_fx_reg    <= fx_in;
        s1_fz_reg    <= fz_in;
        s1_mode_reg  <= mode_in;

        s2_write_reg <= s1_write_reg;
        s2_upper_reg <= s1_upper_reg;
        s2_fx_reg    <= s1_fx_reg;
        s2_fz_reg    <= s1_fz_reg;
        s2_base_reg  <= corner_value(word_base, mode_t'(s1_mode_reg),
                                     height_unit_reg, cliff_unit_reg);
        s2_c1_reg    <= corner_value(word_c1, mode_t'(s1_mode_reg),
                                     height_unit_reg, cliff_unit_reg);
        s2_c2_reg    <= corner_value(word_c2, mode_t'(s1_mode_reg),
                                     height_unit_reg, cliff_unit_reg);

        s3_write_reg <= s2_write_reg;
        s3_base_reg  <= s2_base_reg;
        s3_da_reg    <= da_next;
        s3_db_reg    <= db_next;
        s3_wa_reg    <= wa_next;
        s3_wb_reg    <= wb_next;

        s4_write_reg <= s3_write_reg;
        s4_base_reg  <= s3_base_reg;
        s4_pa_reg    <= pa_next;
        s4_pb_reg    <= pb_next;
    end

    // ---------------- result queue ----------------
    logic [HEIGHT_W-1:0] q_height_reg [Q_DEPTH];
    logic                q_write_reg  [Q_DEPTH];
    logic [Q_PTR_W-1:0]  q_wr_ptr_reg, q_rd_ptr_reg;
    logic [Q_CNT_W-1:0]  q_count_reg, credit_reg;
    logic                out_accept;

    assign out_accept = m_tvalid && m_tready;
    assign m_tvalid   = (q_count_reg != '0);
    assign m_tdata    = OUT_TDATA_W'(q_height_reg[q_rd_ptr_reg]);
    assign m_tuser    = q_write_reg[q_rd_ptr_reg];
    // Every accepted item holds a place until its result leaves.
    assign s_tready   = (credit_reg < Q_CNT_W'(Q_DEPTH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_wr_ptr_reg <= '0;
            q_rd_ptr_reg <= '0;
            q_count_reg  <= '0;
            credit_reg   <= '0;
        end
        else
        begin
            if (s4_valid_reg)
            begin
                q_wr_ptr_reg <= q_wr_ptr_reg + Q_PTR_W'(1);
            end
            if (out_accept)
            begin
                q_rd_ptr_reg <= q_rd_ptr_reg + Q_PTR_W'(1);
            end
            q_count_reg <= q_count_reg + Q_CNT_W'(s4_valid_reg) - Q_CNT_W'(out_accept);
            credit_reg  <= credit_reg + Q_CNT_W'(in_accept) - Q_CNT_W'(out_accept);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s4_valid_reg)
        begin
            q_height_reg[q_wr_ptr_reg] <= height_next;
            q_write_reg[q_wr_ptr_reg]  <= s4_write_reg;
        end
    end

endmodule
